// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== sv/sbe_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse bit-set engine package
// Widths, opcodes, sequencer states and the word count helper.
// ----------------------------------------------------------------------------
`default_nettype none

package sbe_pkg;

    localparam int MAX_WORDS = 64;
    localparam int WORD_W    = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int BITS_W    = 13;
    localparam int OP_W      = 3;

    localparam logic [CNT_W-1:0] FOUND_NONE = '1;
    localparam logic [BITS_W-1:0] BITS_RESET = BITS_W'(4096);

    typedef enum logic [OP_W-1:0] {
        OP_INIT      = 3'd0,
        OP_LOAD      = 3'd1,
        OP_CLEAR     = 3'd2,
        OP_INVERT    = 3'd3,
        OP_OR        = 3'd4,
        OP_INTERSECT = 3'd5,
        OP_QUERY_IDX = 3'd6,
        OP_QUERY_EMP = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOP,
        S_DATA,
        S_EXEC,
        S_SWAP_RD,
        S_SWAP_A,
        S_SWAP_B,
        S_DONE
    } state_t;

    // ceil(bits / 64), saturated at MAX_WORDS
    function automatic logic [CNT_W-1:0] word_count(input logic [BITS_W-1:0] bits);
        logic [BITS_W-1:0] bm1;
        logic [7:0]        n;
        bm1 = bits - BITS_W'(1);
        n   = 8'(bm1 >> 6) + 8'd1;
        if (bits == '0)
            word_count = '0;
        else if (n > 8'(MAX_WORDS))
            word_count = CNT_W'(MAX_WORDS);
        else
            word_count = n[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/sparse_bitset_engine.sv =====
// ----------------------------------------------------------------------------
// Sparse bit-set engine
// Compact-table style sparse bit-set with mask, operand and offset order.
// ----------------------------------------------------------------------------
// Each item is taken when the engine is idle and gives one result. Init, load
// and the empty query go straight to the result state. Clear, invert, OR,
// intersect and the index query walk the active words through one shared
// 64-bit word unit, each word visited taking an order memory read, a word
// memory read and an execute step; the index query stops on a hit, and each
// word that intersect drives to zero adds an order read and the two writes of
// the order swap. Set, mask and order reset values come from per-entry valid
// bits, so reset and init need no clearing pass. The result sits in an output
// register, so the next item is taken while a result waits.
`default_nettype none

module sparse_bitset_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [12:0] cfg_wdata,      // bits_in_use
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // word_index[5:0], word_value[69:6], zero
    input  wire logic [2:0]  s_axis_tuser,   // opcode[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // found_offset[6:0], set_empty[7],
                                             // active_words[14:8], zero
);

`include "assert_macros.svh"

    localparam int W  = sbe_pkg::WORD_W;
    localparam int IW = sbe_pkg::IDX_W;
    localparam int CW = sbe_pkg::CNT_W;

    sbe_pkg::state_t state_reg, state_next;
    sbe_pkg::op_t    op_reg, op_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]   off_reg, off_next;
    logic [CW-1:0]   found_reg, found_next;
    logic [12:0]     bits_reg;
    logic            out_valid_reg, out_valid_next;
    logic [CW-1:0]   out_found_reg, out_found_next;
    logic            out_empty_reg, out_empty_next;
    logic [CW-1:0]   out_cnt_reg, out_cnt_next;

    logic [W-1:0]  set_mem  [sbe_pkg::MAX_WORDS];
    logic [W-1:0]  mask_mem [sbe_pkg::MAX_WORDS];
    logic [W-1:0]  opnd_mem [sbe_pkg::MAX_WORDS];
    logic [IW-1:0] ord_mem  [sbe_pkg::MAX_WORDS];

    logic [sbe_pkg::MAX_WORDS-1:0] set_vld_reg, mask_vld_reg, ord_vld_reg;

    logic [W-1:0]  set_q_reg, mask_q_reg, opnd_q_reg;
    logic          set_vld_q_reg, mask_vld_q_reg, ord_vld_q_reg;
    logic [IW-1:0] ord_q_reg, ord_addr_reg;

    logic [IW-1:0] ord_raddr, ord_waddr, ord_wdata, ord_res;
    logic          ord_we;
    logic [IW-1:0] dat_raddr;
    logic          set_we, mask_we, opnd_we, init_clr;
    logic [W-1:0]  set_wdata, mask_wdata;
    logic [W-1:0]  set_d, mask_d, and_w;
    logic [CW-1:0] pos_m1, cnt_m1;
    logic          accept;

    assign s_axis_tready = (state_reg == sbe_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_cnt_reg, out_empty_reg, out_found_reg};

    assign pos_m1    = pos_reg - CW'(1);
    assign cnt_m1    = cnt_reg - CW'(1);
    assign ord_res   = ord_vld_q_reg ? ord_q_reg : ord_addr_reg;
    assign dat_raddr = ord_res;
    assign set_d     = set_vld_q_reg ? set_q_reg : '1;
    assign mask_d    = mask_vld_q_reg ? mask_q_reg : '0;
    assign and_w     = set_d & mask_d;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        off_next       = off_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_found_next = out_found_reg;
        out_empty_next = out_empty_reg;
        out_cnt_next   = out_cnt_reg;
        ord_raddr      = pos_reg[IW-1:0];
        ord_we         = 1'b0;
        ord_waddr      = pos_m1[IW-1:0];
        ord_wdata      = ord_res;
        set_we         = 1'b0;
        set_wdata      = and_w;
        mask_we        = 1'b0;
        mask_wdata     = '0;
        opnd_we        = 1'b0;
        init_clr       = 1'b0;

        case (state_reg)
            sbe_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = sbe_pkg::op_t'(s_axis_tuser);
                    found_next = sbe_pkg::FOUND_NONE;
                    pos_next   = '0;
                    state_next = sbe_pkg::S_LOOP;
                    case (sbe_pkg::op_t'(s_axis_tuser))
                        sbe_pkg::OP_INIT:
                        begin
                            init_clr   = 1'b1;
                            cnt_next   = sbe_pkg::word_count(bits_reg);
                            state_next = sbe_pkg::S_DONE;
                        end
                        sbe_pkg::OP_LOAD:
                        begin
                            opnd_we    = 1'b1;
                            state_next = sbe_pkg::S_DONE;
                        end
                        sbe_pkg::OP_QUERY_EMP: state_next = sbe_pkg::S_DONE;
                        sbe_pkg::OP_INTERSECT: pos_next = cnt_reg;
                        default:               pos_next = '0;
                    endcase
                end
            end
            sbe_pkg::S_LOOP:
            begin
                if (op_reg == sbe_pkg::OP_INTERSECT)
                begin
                    ord_raddr = pos_m1[IW-1:0];
                    state_next = (pos_reg == '0) ? sbe_pkg::S_DONE : sbe_pkg::S_DATA;
                end
                else
                begin
                    ord_raddr = pos_reg[IW-1:0];
                    state_next = (pos_reg >= cnt_reg) ? sbe_pkg::S_DONE : sbe_pkg::S_DATA;
                end
            end
            sbe_pkg::S_DATA:
            begin
                off_next   = ord_res;
                state_next = sbe_pkg::S_EXEC;
            end
            sbe_pkg::S_EXEC:
            begin
                state_next = sbe_pkg::S_LOOP;
                pos_next   = pos_reg + CW'(1);
                case (op_reg)
                    sbe_pkg::OP_CLEAR:
                    begin
                        mask_we    = 1'b1;
                        mask_wdata = '0;
                    end
                    sbe_pkg::OP_INVERT:
                    begin
                        mask_we    = 1'b1;
                        mask_wdata = ~mask_d;
                    end
                    sbe_pkg::OP_OR:
                    begin
                        mask_we    = 1'b1;
                        mask_wdata = mask_d | opnd_q_reg;
                    end
                    sbe_pkg::OP_QUERY_IDX:
                    begin
                        if ((set_d & opnd_q_reg) != '0)
                        begin
                            found_next = CW'(off_reg);
                            state_next = sbe_pkg::S_DONE;
                        end
                    end
                    sbe_pkg::OP_INTERSECT:
                    begin
                        pos_next = pos_m1;
                        if (and_w != set_d)
                        begin
                            set_we = 1'b1;
                            if (and_w == '0)
                            begin
                                pos_next   = pos_reg;
                                state_next = sbe_pkg::S_SWAP_RD;
                            end
                        end
                    end
                    default: state_next = sbe_pkg::S_DONE;
                endcase
            end
            sbe_pkg::S_SWAP_RD:
            begin
                ord_raddr  = cnt_m1[IW-1:0];
                state_next = sbe_pkg::S_SWAP_A;
            end
            sbe_pkg::S_SWAP_A:
            begin
                ord_we     = 1'b1;
                ord_waddr  = pos_m1[IW-1:0];
                ord_wdata  = ord_res;
                state_next = sbe_pkg::S_SWAP_B;
            end
            sbe_pkg::S_SWAP_B:
            begin
                ord_we     = 1'b1;
                ord_waddr  = cnt_m1[IW-1:0];
                ord_wdata  = off_reg;
                cnt_next   = cnt_m1;
                pos_next   = pos_m1;
                state_next = sbe_pkg::S_LOOP;
            end
            sbe_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found_reg;
                    out_empty_next = (cnt_reg == '0);
                    out_cnt_next   = cnt_reg;
                    state_next     = sbe_pkg::S_IDLE;
                end
            end
            default: state_next = sbe_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbe_pkg::S_IDLE;
            op_reg        <= sbe_pkg::OP_INIT;
            pos_reg       <= '0;
            cnt_reg       <= CW'(sbe_pkg::MAX_WORDS);
            found_reg     <= sbe_pkg::FOUND_NONE;
            bits_reg      <= sbe_pkg::BITS_RESET;
            out_valid_reg <= 1'b0;
            set_vld_reg   <= '0;
            mask_vld_reg  <= '0;
            ord_vld_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                bits_reg <= cfg_wdata;
            if (init_clr)
            begin
                set_vld_reg  <= '0;
                mask_vld_reg <= '0;
                ord_vld_reg  <= '0;
            end
            else
            begin
                if (set_we)
                    set_vld_reg[off_reg] <= 1'b1;
                if (mask_we)
                    mask_vld_reg[off_reg] <= 1'b1;
                if (ord_we)
                    ord_vld_reg[ord_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg       <= off_next;
        out_found_reg <= out_found_next;
        out_empty_reg <= out_empty_next;
        out_cnt_reg   <= out_cnt_next;
    end

    // word and order memories, registered reads
    always_ff @(posedge clk)
    begin
        if (set_we)
            set_mem[off_reg] <= set_wdata;
        if (mask_we)
            mask_mem[off_reg] <= mask_wdata;
        if (opnd_we)
            opnd_mem[s_axis_tdata[5:0]] <= s_axis_tdata[69:6];
        if (ord_we)
            ord_mem[ord_waddr] <= ord_wdata;
        set_q_reg      <= set_mem[dat_raddr];
        mask_q_reg     <= mask_mem[dat_raddr];
        opnd_q_reg     <= opnd_mem[dat_raddr];
        set_vld_q_reg  <= set_vld_reg[dat_raddr];
        mask_vld_q_reg <= mask_vld_reg[dat_raddr];
        ord_q_reg      <= ord_mem[ord_raddr];
        ord_vld_q_reg  <= ord_vld_reg[ord_raddr];
        ord_addr_reg   <= ord_raddr;
    end

    `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_reg <= CW'(sbe_pkg::MAX_WORDS),
        "active word count above MAX_WORDS")
    `ASSERT_NEXT(a_cnt_shrinks, clk, rst_n, state_reg != sbe_pkg::S_IDLE,
        cnt_reg <= $past(cnt_reg), "active word count grew during a walk")
    `ASSERT_ALWAYS(a_fwd_pos, clk, rst_n,
        !(state_reg == sbe_pkg::S_EXEC && op_reg != sbe_pkg::OP_INTERSECT)
        || pos_reg < cnt_reg, "forward walk beyond active prefix")
    `ASSERT_ALWAYS(a_bwd_pos, clk, rst_n,
        !(state_reg == sbe_pkg::S_EXEC && op_reg == sbe_pkg::OP_INTERSECT)
        || (pos_reg != '0 && pos_reg <= cnt_reg), "intersect walk out of range")
    `ASSERT_NEXT(a_done_out, clk, rst_n,
        state_reg == sbe_pkg::S_DONE && state_next == sbe_pkg::S_IDLE,
        out_valid_reg, "result not presented after completion")

endmodule

`default_nettype wire
